// ----- hw/rtl/z_text_char_decoder_defines.svh -----
// Assertion macros for the text decoder.
// Taken in by files that carry concurrent checks; no other dependencies.
`ifndef Z_TEXT_CHAR_DECODER_DEFINES_SVH
`define Z_TEXT_CHAR_DECODER_DEFINES_SVH

// antecedent implies consequent in the same cycle
`define ZDEC_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// antecedent implies consequent in the next cycle
`define ZDEC_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- hw/rtl/zdec_pkg.sv -----
// Shared types, codes and character tables for the text decoder.
// No dependencies; used by the lane, merge and top-level modules.
package zdec_pkg;

	localparam int NUM_LANES = 3;
	localparam int CODE_W    = 5;
	localparam int WORD_W    = 16;
	localparam int VER_W     = 4;
	localparam int ADDR_W    = 16;
	localparam int CHAR_W    = 8;
	localparam int KIND_W    = 2;
	localparam int CFG_IDX_W = 1;
	localparam int CFG_DAT_W = 16;
	localparam int CNT_W     = 2;

	// config register indexes
	localparam logic [CFG_IDX_W-1:0] REG_VERSION = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_ABBREV_BASE = 1'd1;

	localparam logic [VER_W-1:0]  VERSION_RST  = 4'd3;
	localparam logic [VER_W-1:0]  VERSION_ABBR = 4'd3;
	localparam logic [ADDR_W-1:0] BASE_RST     = 16'd0;

	// decode status
	localparam logic [1:0] ST_NORMAL = 2'd0;
	localparam logic [1:0] ST_ABBREV = 2'd1;
	localparam logic [1:0] ST_ESC_HI = 2'd2;
	localparam logic [1:0] ST_ESC_LO = 2'd3;

	// alphabet rows
	localparam logic [1:0] ROW_LOWER = 2'd0;
	localparam logic [1:0] ROW_UPPER = 2'd1;
	localparam logic [1:0] ROW_PUNCT = 2'd2;

	// result kinds
	localparam logic [KIND_W-1:0] KIND_CHAR   = 2'd0;
	localparam logic [KIND_W-1:0] KIND_ABBREV = 2'd1;
	localparam logic [KIND_W-1:0] KIND_NONE   = 2'd2;

	// special codes
	localparam logic [CODE_W-1:0] CODE_SPACE      = 5'd0;
	localparam logic [CODE_W-1:0] CODE_ABBR_LAST  = 5'd3;
	localparam logic [CODE_W-1:0] CODE_FIRST_CHAR = 5'd6;
	localparam logic [CODE_W-1:0] CODE_ESCAPE     = 5'd6;

	localparam logic [CHAR_W-1:0] CHAR_SPACE = 8'h20;
	localparam logic [CHAR_W-1:0] CHAR_LOWER = 8'h61;
	localparam logic [CHAR_W-1:0] CHAR_UPPER = 8'h41;
	localparam logic [ADDR_W-1:0] ABBR_BLOCK = 16'd64;

	typedef struct packed {
		logic [1:0]        shift;
		logic [1:0]        status;
		logic [CODE_W-1:0] prev;
	} dec_state_t;

	typedef struct packed {
		logic              vld;
		logic [KIND_W-1:0] kind;
		logic [CHAR_W-1:0] chr;
		logic [ADDR_W-1:0] addr;
	} lane_res_t;

	typedef struct packed {
		lane_res_t [NUM_LANES-1:0] res;
		logic                      end_bit;
	} word_res_t;

	// third alphabet row, index = code - 6
	function automatic logic [CHAR_W-1:0] punct_char(input logic [CODE_W-1:0] idx);
		logic [CHAR_W-1:0] ch;
		case (idx)
			5'd0:    ch = 8'h20; // space
			5'd1:    ch = 8'h5e; // ^
			5'd2:    ch = 8'h30;
			5'd3:    ch = 8'h31;
			5'd4:    ch = 8'h32;
			5'd5:    ch = 8'h33;
			5'd6:    ch = 8'h34;
			5'd7:    ch = 8'h35;
			5'd8:    ch = 8'h36;
			5'd9:    ch = 8'h37;
			5'd10:   ch = 8'h38;
			5'd11:   ch = 8'h39;
			5'd12:   ch = 8'h2e; // .
			5'd13:   ch = 8'h2c; // ,
			5'd14:   ch = 8'h21; // !
			5'd15:   ch = 8'h3f; // ?
			5'd16:   ch = 8'h5f; // _
			5'd17:   ch = 8'h23; // #
			5'd18:   ch = 8'h27; // '
			5'd19:   ch = 8'h22; // "
			5'd20:   ch = 8'h2f; // /
			5'd21:   ch = 8'h5c; // backslash
			5'd22:   ch = 8'h2d; // -
			5'd23:   ch = 8'h3a; // :
			5'd24:   ch = 8'h28; // (
			5'd25:   ch = 8'h29; // )
			default: ch = 8'h20;
		endcase
		return ch;
	endfunction

	function automatic logic [CHAR_W-1:0] row_char(input logic [1:0] row,
			input logic [CODE_W-1:0] idx);
		logic [CHAR_W-1:0] ch;
		case (row)
			ROW_LOWER: ch = CHAR_LOWER + {3'd0, idx};
			ROW_UPPER: ch = CHAR_UPPER + {3'd0, idx};
			default:   ch = punct_char(idx);
		endcase
		return ch;
	endfunction

endpackage

// ----- hw/rtl/zdec_lane.sv -----
// One decode lane: handles a single 5-bit code given the state left by the
// code before it. Depends on zdec_pkg.
module zdec_lane (
	input  zdec_pkg::dec_state_t               st_in,
	input  logic [zdec_pkg::CODE_W-1:0]        code,
	input  logic [zdec_pkg::VER_W-1:0]         version,
	input  logic [zdec_pkg::ADDR_W-1:0]        abbrev_base,
	output zdec_pkg::dec_state_t               st_out,
	output zdec_pkg::lane_res_t                res
);
	import zdec_pkg::*;

	logic [ADDR_W-1:0] entry_addr;

	// base + 64*(prev-1) + 2*code, wrapping at 16 bits
	assign entry_addr = abbrev_base + {5'd0, st_in.prev, 6'd0} - ABBR_BLOCK
		+ {10'd0, code, 1'b0};

	always_comb begin
		st_out      = st_in;
		st_out.prev = code;
		res         = '0;
		res.kind    = KIND_CHAR;
		case (st_in.status)
			ST_NORMAL: begin
				if (st_in.shift == ROW_PUNCT && code == CODE_ESCAPE) begin
					st_out.status = ST_ESC_HI;
					st_out.shift  = ROW_LOWER;
				end else if (code >= CODE_FIRST_CHAR) begin
					res.vld      = 1'b1;
					res.chr      = row_char(st_in.shift, code - CODE_FIRST_CHAR);
					st_out.shift = ROW_LOWER;
				end else if (code == CODE_SPACE) begin
					res.vld      = 1'b1;
					res.chr      = CHAR_SPACE;
					st_out.shift = ROW_LOWER;
				end else if (version >= VERSION_ABBR && code <= CODE_ABBR_LAST) begin
					st_out.status = ST_ABBREV;
					st_out.shift  = ROW_LOWER;
				end else begin
					// shift codes: odd picks punctuation, even picks uppercase
					st_out.shift = code[0] ? ROW_PUNCT : ROW_UPPER;
				end
			end
			ST_ABBREV: begin
				res.vld       = 1'b1;
				res.kind      = KIND_ABBREV;
				res.addr      = entry_addr;
				st_out.status = ST_NORMAL;
			end
			ST_ESC_HI: begin
				st_out.status = ST_ESC_LO;
			end
			default: begin
				res.vld       = 1'b1;
				res.chr       = {st_in.prev[2:0], code};
				st_out.status = ST_NORMAL;
			end
		endcase
	end

endmodule

// ----- hw/rtl/zdec_merge.sv -----
// Merge stage: packs the lane results of one word into a short list and
// hands them out one per cycle while out_ready is high. Depends on zdec_pkg and the defines header.
`include "z_text_char_decoder_defines.svh"

module zdec_merge (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              load,
	input  zdec_pkg::word_res_t               wres,
	output logic                              take_ready,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic [zdec_pkg::KIND_W-1:0]       out_kind,
	output logic [zdec_pkg::CHAR_W-1:0]       out_char,
	output logic [zdec_pkg::ADDR_W-1:0]       out_addr,
	output logic                              out_last,
	output logic                              out_end
);
	import zdec_pkg::*;

	typedef struct packed {
		logic [KIND_W-1:0] kind;
		logic [CHAR_W-1:0] chr;
		logic [ADDR_W-1:0] addr;
	} item_t;

	item_t            items_q [NUM_LANES];
	item_t            items_d [NUM_LANES];
	logic [CNT_W-1:0] num_q;
	logic [CNT_W-1:0] num_d;
	logic [CNT_W-1:0] idx_q;
	logic             busy_q;
	logic             end_q;
	logic [CNT_W-1:0] cnt;
	logic             last;

	// compact valid lanes, keep code order
	always_comb begin
		cnt = '0;
		for (int i = 0; i < NUM_LANES; i++) begin
			items_d[i] = '0;
		end
		items_d[0].kind = KIND_NONE;
		for (int i = 0; i < NUM_LANES; i++) begin
			if (wres.res[i].vld) begin
				items_d[cnt] = '{kind: wres.res[i].kind, chr: wres.res[i].chr,
					addr: wres.res[i].addr};
				cnt = cnt + 1'b1;
			end
		end
		num_d = (cnt == '0) ? CNT_W'(1) : cnt;
	end

	assign last       = (idx_q == num_q - 1'b1);
	assign take_ready = !busy_q || (out_ready && last);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			idx_q  <= '0;
			num_q  <= CNT_W'(1);
			end_q  <= 1'b0;
		end else if (load) begin
			busy_q <= 1'b1;
			idx_q  <= '0;
			num_q  <= num_d;
			end_q  <= wres.end_bit;
		end else if (busy_q && out_ready) begin
			if (last) begin
				busy_q <= 1'b0;
				idx_q  <= '0;
			end else begin
				idx_q <= idx_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			for (int i = 0; i < NUM_LANES; i++) begin
				items_q[i] <= items_d[i];
			end
		end
	end

	assign out_valid = busy_q;
	assign out_kind  = items_q[idx_q].kind;
	assign out_char  = items_q[idx_q].chr;
	assign out_addr  = items_q[idx_q].addr;
	assign out_last  = last;
	assign out_end   = end_q;

	`ZDEC_ASSERT_IMP(a_idx_in_range, clk, arst_n, busy_q, idx_q < num_q, "read index past list")
	`ZDEC_ASSERT_IMP(a_idle_idx_zero, clk, arst_n, !busy_q, idx_q == '0, "idle with index set")
	`ZDEC_ASSERT_NXT(a_stall_holds, clk, arst_n, busy_q && !out_ready,
		busy_q && $stable(idx_q) && $stable(num_q) && $stable(end_q), "list moved on stall")
	`ZDEC_ASSERT_NXT(a_step_one, clk, arst_n, busy_q && out_ready && !last,
		busy_q && idx_q == $past(idx_q) + 1'b1, "index skipped a result")

endmodule

// ----- hw/rtl/z_text_char_decoder.sv -----
// Packed-text character decoder, top level.
// Depends on zdec_pkg, zdec_lane and zdec_merge.
//
// Usage:
//   Input channel (in_valid/in_ready, text_word): one 16-bit word per item,
//   three 5-bit codes in bits 14..10, 9..5, 4..0, bit 15 set on a string's
//   last word. Output channel (out_valid/out_ready): one result per item,
//   1 to 3 results per word, in code order. last_of_word marks a word's final
//   result; a word that yields nothing gives one result of kind "nothing".
//   Config channel (cfg_valid/cfg_ready, cfg_index, cfg_data): index 0 is the
//   format version (low 4 bits), index 1 the abbreviation table base. Always
//   ready; write only while the decoder has no words in flight.
// Timing:
//   Three lanes decode the three codes of a word in the cycle it is accepted;
//   the merge stage registers the packed list, so the first result is valid
//   in the cycle after acceptance. Results leave at one per cycle while
//   out_ready is high, so the output port sets the sustained word rate.
//   The next word is taken in the cycle the last result of the current one
//   is taken.
// Reset: decode state clears to lowercase/normal, version 3, base 0.
//   A stalled receiver holds the current result and blocks new words.
module z_text_char_decoder (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	output logic                               in_ready,
	input  logic [zdec_pkg::WORD_W-1:0]        text_word,
	output logic                               out_valid,
	input  logic                               out_ready,
	output logic [zdec_pkg::KIND_W-1:0]        result_kind,
	output logic [zdec_pkg::CHAR_W-1:0]        char_code,
	output logic [zdec_pkg::ADDR_W-1:0]        abbrev_pointer_addr,
	output logic                               last_of_word,
	output logic                               string_end,
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [zdec_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [zdec_pkg::CFG_DAT_W-1:0]     cfg_data
);
	import zdec_pkg::*;

	logic [VER_W-1:0]  version_q;
	logic [ADDR_W-1:0] abbrev_base_q;
	dec_state_t        state_q;
	dec_state_t        st_chain [NUM_LANES+1];
	lane_res_t         lane_res [NUM_LANES];
	word_res_t         wres;
	logic              take_ready;
	logic              load;

	// config registers, to be written only while idle; the block itself does not enforce this
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			version_q     <= VERSION_RST;
			abbrev_base_q <= BASE_RST;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_VERSION:     version_q     <= cfg_data[VER_W-1:0];
				REG_ABBREV_BASE: abbrev_base_q <= cfg_data[ADDR_W-1:0];
				default: ;
			endcase
		end
	end

	// lane i takes the state left by lane i-1; only narrow state is chained
	assign st_chain[0] = state_q;

	for (genvar i = 0; i < NUM_LANES; i++) begin : g_lane
		zdec_lane u_lane (
			.st_in       (st_chain[i]),
			.code        (text_word[(NUM_LANES-i)*CODE_W-1 -: CODE_W]),
			.version     (version_q),
			.abbrev_base (abbrev_base_q),
			.st_out      (st_chain[i+1]),
			.res         (lane_res[i])
		);
	end

	always_comb begin
		wres.end_bit = text_word[WORD_W-1];
		for (int i = 0; i < NUM_LANES; i++) begin
			wres.res[i] = lane_res[i];
		end
	end

	assign in_ready = take_ready;
	assign load     = in_valid && take_ready;

	// decode state advances per word; the string end bit clears it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '0;
		end else if (load) begin
			if (text_word[WORD_W-1]) begin
				state_q <= '0;
			end else begin
				state_q <= st_chain[NUM_LANES];
			end
		end
	end

	zdec_merge u_merge (
		.clk        (clk),
		.arst_n     (arst_n),
		.load       (load),
		.wres       (wres),
		.take_ready (take_ready),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.out_kind   (result_kind),
		.out_char   (char_code),
		.out_addr   (abbrev_pointer_addr),
		.out_last   (last_of_word),
		.out_end    (string_end)
	);

endmodule
